@@ hdl/cht_pkg.sv @@
// Package: sizes, command codes and shared control types for the chained hash table.
`default_nettype none
package cht_pkg;
   localparam int Buckets   = 64;
   localparam int Nodes     = 256;
   localparam int BktW      = $clog2(Buckets);
   localparam int NodeW     = $clog2(Nodes);
   localparam int PtrW      = NodeW + 1;
   localparam int CfgW      = 7;
   localparam int KeyW      = 32;
   localparam int ValW      = 32;
   localparam int CmdW      = 2;

   typedef enum logic [CmdW-1:0] {
      CMD_SET    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_HAS    = 2'd3
   } cmd_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, start modulo
      logic mod_step;   // one subtract step of key modulo
      logic head_rd;    // read bucket head into cursor
      logic node_rd;    // issue node read at cursor
      logic advance;    // prev <= cur, cur <= next
      logic free_step;  // scan one pool entry for a free node
      logic do_write;   // apply the update for the command
      logic rsp_load;   // load result register
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic mod_done;
      logic cur_null;
      logic key_match;
      logic walk_limit;
      logic free_found;
      logic free_end;
   } sts_type;
endpackage
`default_nettype wire

@@ hdl/cht_if.sv @@
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface cht_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                cmd;
   logic [31:0]               key;
   logic [31:0]               value;
   modport source  (output valid, cmd, key, value, input ready);
   modport sink    (input valid, cmd, key, value, output ready);
   modport monitor (input valid, ready, cmd, key, value);
endinterface

interface cht_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] value_out;
   logic        status;
   modport source  (output valid, found, value_out, status, input ready);
   modport sink    (input valid, found, value_out, status, output ready);
   modport monitor (input valid, ready, found, value_out, status);
endinterface
`default_nettype wire

@@ hdl/chained_hash_table.sv @@
// Top level of the chained hash table: controller, datapath and channel wiring.
//
//  channel | dir | handshake         | payload
//  req     | in  | req_valid/ready   | cmd, key, value
//  rsp     | out | rsp_valid/ready   | found, value_out, status
//  csr     | in  | csr_we            | bucket_count (7 bits)
//
// One request at a time: accept, modulo (32 restoring steps), head read, a read and a compare
// per chain node and a check at the chain end, a free-pool scan for a set of a new key,
// then update and respond.
// Reset (synchronous) empties all bucket heads and the pool.
// A waiting response holds the next request in the update step.
`default_nettype none
module chained_hash_table (
   input  wire logic   clock,
   input  wire logic   reset,
   cht_req_if.sink     req,
   cht_rsp_if.source   rsp,
   input  wire logic   csr_we,
   input  wire logic [cht_pkg::CfgW-1:0] csr_wdata
);
   import cht_pkg::*;

   ctl_type    ctl;
   sts_type    sts;
   logic [1:0] cmd_q;
   logic       rsp_busy;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .cmd       (cmd_q),
      .rsp_busy  (rsp_busy),
      .ctl       (ctl),
      .sts       (sts)
   );

   cht_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_cmd       (req.cmd),
      .req_key       (req.key),
      .req_value     (req.value),
      .cmd_q         (cmd_q),
      .ctl           (ctl),
      .sts           (sts),
      .rsp_busy      (rsp_busy),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_found     (rsp.found),
      .rsp_value_out (rsp.value_out),
      .rsp_status    (rsp.status)
   );

`ifndef NO_ASSERTIONS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.mod_step, ctl.head_rd, ctl.node_rd, ctl.advance, ctl.free_step}))
      else $error("more than one datapath step at once");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |=> !req.ready)
      else $error("request taken while response loading");
   a_status_set: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status) |-> !rsp.found)
      else $error("pool full flagged on a hit");
`endif
endmodule
`default_nettype wire

@@ hdl/cht_ctrl.sv @@
// Controller state machine: sequences modulo, chain walk, free search and update.
`default_nettype none
module cht_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        cmd,
   input  wire logic              rsp_busy,
   output cht_pkg::ctl_type       ctl,
   input  wire cht_pkg::sts_type  sts
);
   import cht_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MOD   = 8'b0000_0010,
      S_HEAD  = 8'b0000_0100,
      S_RD    = 8'b0000_1000,
      S_CHK   = 8'b0001_0000,
      S_FREE  = 8'b0010_0000,
      S_WR    = 8'b0100_0000,
      S_RSP   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (sts.mod_done) state_in = S_HEAD;
            else ctl.mod_step = 1'b1;
         end
         S_HEAD: begin
            ctl.head_rd = 1'b1;
            state_in    = S_RD;
         end
         S_RD: begin
            if (sts.cur_null || sts.walk_limit) begin
               state_in = (cmd == CMD_SET) ? S_FREE : S_WR;
            end else begin
               ctl.node_rd = 1'b1;
               state_in    = S_CHK;
            end
         end
         S_CHK: begin
            if (sts.key_match) state_in = S_WR;
            else begin
               ctl.advance = 1'b1;
               state_in    = S_RD;
            end
         end
         S_FREE: begin
            if (sts.free_found || sts.free_end) state_in = S_WR;
            else ctl.free_step = 1'b1;
         end
         S_WR: begin
            if (!rsp_busy) begin
               ctl.do_write = 1'b1;
               ctl.rsp_load = 1'b1;
               state_in     = S_RSP;
            end
         end
         S_RSP: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

@@ hdl/cht_dp.sv @@
// Datapath: request registers, modulo unit, bucket heads, node pool and result register.
`default_nettype none
module cht_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [cht_pkg::CfgW-1:0] csr_wdata,
   input  wire logic [1:0]             req_cmd,
   input  wire logic [31:0]            req_key,
   input  wire logic [31:0]            req_value,
   output logic [1:0]                  cmd_q,
   input  wire cht_pkg::ctl_type       ctl,
   output cht_pkg::sts_type            sts,
   output logic                        rsp_busy,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_found,
   output logic [31:0]                 rsp_value_out,
   output logic                        rsp_status
);
   import cht_pkg::*;

   logic [CfgW-1:0]  cfg_ff;
   logic [CfgW-1:0]  nb;
   logic [1:0]       cmd_ff;
   logic [KeyW-1:0]  key_ff;
   logic [ValW-1:0]  val_ff;
   logic [KeyW-1:0]  rem_ff;
   logic [5:0]       mstep_ff;     // shift step of restoring modulo, 31..0
   logic             mdone_ff;
   logic [BktW-1:0]  bkt;
   logic [PtrW-1:0]  head_ff [Buckets];
   logic [Buckets-1:0] head_vld_ff;
   logic [PtrW-1:0]  cur_ff, prev_ff;
   logic [PtrW:0]    steps_ff;
   logic [KeyW-1:0]  node_key   [Nodes];
   logic [ValW-1:0]  node_val   [Nodes];
   logic [PtrW-1:0]  node_next  [Nodes];
   logic [Nodes-1:0] in_use_ff;
   logic [KeyW-1:0]  rd_key_ff;
   logic [ValW-1:0]  rd_val_ff;
   logic [PtrW-1:0]  rd_next_ff;
   logic [PtrW-1:0]  fidx_ff;
   logic             rv_ff, rf_ff, rs_ff;
   logic [ValW-1:0]  rval_ff;
   logic [KeyW+6:0]  trial;
   logic [NodeW-1:0] cur_a, prev_a, free_a;
   logic             node_next_fix_ff;
   logic [NodeW-1:0] fix_a_ff;

   assign cmd_q = cmd_ff;
   assign nb = (cfg_ff == '0) ? CfgW'(1) :
               (cfg_ff > CfgW'(Buckets)) ? CfgW'(Buckets) : cfg_ff;
   assign bkt    = rem_ff[BktW-1:0];
   assign cur_a  = cur_ff[NodeW-1:0];
   assign prev_a = prev_ff[NodeW-1:0];
   assign free_a = fidx_ff[NodeW-1:0];
   // divisor is at most 64: shifted by mstep, one restoring step per cycle
   assign trial  = {7'd0, rem_ff} - ({32'd0, nb} << mstep_ff);

   assign sts.mod_done   = mdone_ff;
   assign sts.cur_null   = cur_ff[NodeW];
   assign sts.key_match  = rd_key_ff == key_ff;
   assign sts.walk_limit = steps_ff >= (PtrW+1)'(Nodes);
   assign sts.free_found = (fidx_ff[NodeW] == 1'b0) && !in_use_ff[free_a];
   assign sts.free_end   = fidx_ff[NodeW];

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= CfgW'(Buckets);
      else if (csr_we) cfg_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_key;
         val_ff   <= req_value;
         rem_ff   <= req_key;
         mstep_ff <= 6'd31;
         mdone_ff <= 1'b0;
      end else if (ctl.mod_step) begin
         if (!trial[KeyW+6]) rem_ff <= trial[KeyW-1:0];
         if (mstep_ff == 6'd0) mdone_ff <= 1'b1;
         else mstep_ff <= mstep_ff - 6'd1;
      end
   end

   // chain cursor; a bucket never written reads as empty
   always_ff @(posedge clock) begin
      if (ctl.head_rd) begin
         cur_ff   <= head_vld_ff[bkt] ? head_ff[bkt] : PtrW'(Nodes);
         prev_ff  <= PtrW'(Nodes);
         steps_ff <= '0;
         fidx_ff  <= '0;
      end else if (ctl.advance) begin
         prev_ff  <= cur_ff;
         cur_ff   <= rd_next_ff;
         steps_ff <= steps_ff + 1'b1;
      end else if (ctl.free_step) begin
         fidx_ff  <= fidx_ff + 1'b1;
      end
   end

   // node memories, registered read
   always_ff @(posedge clock) begin
      if (ctl.node_rd) begin
         rd_key_ff  <= node_key[cur_a];
         rd_val_ff  <= node_val[cur_a];
         rd_next_ff <= node_next[cur_a];
      end
   end

   logic hit;
   assign hit = !cur_ff[NodeW] && !sts.walk_limit && (rd_key_ff == key_ff);

   // head table, valid bits clear at reset
   always_ff @(posedge clock) begin
      if (reset) head_vld_ff <= '0;
      else if (ctl.do_write) begin
         if ((cmd_ff == CMD_SET && !hit && !fidx_ff[NodeW] && prev_ff[NodeW]) ||
             (cmd_ff == CMD_REMOVE && hit && prev_ff[NodeW]))
            head_vld_ff[bkt] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.do_write) begin
         if (cmd_ff == CMD_SET && !hit && !fidx_ff[NodeW] && prev_ff[NodeW])
            head_ff[bkt] <= fidx_ff;
         else if (cmd_ff == CMD_REMOVE && hit && prev_ff[NodeW])
            head_ff[bkt] <= rd_next_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) in_use_ff <= '0;
      else if (ctl.do_write) begin
         if (cmd_ff == CMD_SET && !hit && !fidx_ff[NodeW]) in_use_ff[free_a] <= 1'b1;
         else if (cmd_ff == CMD_REMOVE && hit) in_use_ff[cur_a] <= 1'b0;
      end
   end

   // one write per memory per cycle
   always_ff @(posedge clock) begin
      if (ctl.do_write && cmd_ff == CMD_SET) begin
         if (hit) node_val[cur_a] <= val_ff;
         else if (!fidx_ff[NodeW]) begin
            node_val[free_a] <= val_ff;
            node_key[free_a] <= key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.do_write) begin
         if (cmd_ff == CMD_SET && !hit && !fidx_ff[NodeW] && !prev_ff[NodeW])
            node_next[prev_a] <= fidx_ff;
         else if (cmd_ff == CMD_SET && !hit && !fidx_ff[NodeW])
            node_next[free_a] <= PtrW'(Nodes);
         else if (cmd_ff == CMD_REMOVE && hit && !prev_ff[NodeW])
            node_next[prev_a] <= rd_next_ff;
      end else if (node_next_fix_ff) begin
         node_next[fix_a_ff] <= PtrW'(Nodes);
      end
   end

   // new tail's next is fixed in the cycle after linking
   always_ff @(posedge clock) begin
      if (reset) node_next_fix_ff <= 1'b0;
      else node_next_fix_ff <= ctl.rsp_load && cmd_ff == CMD_SET && !hit &&
                               !fidx_ff[NodeW] && !prev_ff[NodeW];
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) fix_a_ff <= free_a;
   end

   // result register
   assign rsp_busy      = rv_ff;
   assign rsp_valid     = rv_ff;
   assign rsp_found     = rf_ff;
   assign rsp_value_out = rval_ff;
   assign rsp_status    = rs_ff;

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (ctl.rsp_load) rv_ff <= 1'b1;
      else if (rsp_ready) rv_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rf_ff   <= hit;
         rval_ff <= (hit && (cmd_ff == CMD_GET || cmd_ff == CMD_REMOVE)) ? rd_val_ff : '0;
         rs_ff   <= (cmd_ff == CMD_SET) && !hit && fidx_ff[NodeW];
      end
   end
endmodule
`default_nettype wire

@@ test/cht_checker.sv @@
// Checker: predicts hash table responses from observed request transfers and compares them.
`timescale 1ns / 1ps
module cht_checker (
   input  wire logic  clock,
   input  wire logic  reset,
   cht_req_if.monitor req,
   cht_rsp_if.monitor rsp,
   input  wire logic  csr_we,
   input  wire logic [cht_pkg::CfgW-1:0] csr_wdata,
   output int         fail_count,
   output int         pending_count
);
   import cht_pkg::*;

   typedef struct packed {
      logic            found;
      logic [ValW-1:0] value_out;
      logic            status;
   } answer_type;

   logic [CfgW-1:0] bkt_cfg;
   logic [PtrW-1:0] head_ptr [Buckets];
   logic [KeyW-1:0] pool_key [Nodes];
   logic [ValW-1:0] pool_val [Nodes];
   logic [PtrW-1:0] pool_next [Nodes];
   logic            pool_used [Nodes];
   answer_type      answers_due [$];

   function automatic int buckets_active();
      if (bkt_cfg == 0) return 1;
      if (bkt_cfg > Buckets) return Buckets;
      return int'(bkt_cfg);
   endfunction

   task automatic clear_table();
      bkt_cfg = 7'd64;
      foreach (head_ptr[i]) head_ptr[i] = PtrW'(Nodes);
      foreach (pool_used[i]) begin
         pool_used[i] = 1'b0;
         pool_next[i] = PtrW'(Nodes);
         pool_key[i] = '0;
         pool_val[i] = '0;
      end
   endtask

   function automatic answer_type apply_request(cmd_type op, logic [KeyW-1:0] k,
                                                logic [ValW-1:0] v);
      int b, cur, prev, steps, n;
      answer_type a;
      a = '0;
      b = int'(k % 32'(buckets_active()));
      cur = head_ptr[b];
      prev = Nodes;
      steps = 0;
      while (cur < Nodes && steps < Nodes) begin
         if (pool_key[cur] == k) begin
            a.found = 1'b1;
            break;
         end
         prev = cur;
         cur = pool_next[cur];
         steps++;
      end
      case (op)
         CMD_SET: begin
            if (a.found) pool_val[cur] = v;
            else begin
               for (n = 0; n < Nodes; n++) if (!pool_used[n]) break;
               if (n >= Nodes) a.status = 1'b1;
               else begin
                  pool_used[n] = 1'b1;
                  pool_key[n] = k;
                  pool_val[n] = v;
                  pool_next[n] = PtrW'(Nodes);
                  if (prev < Nodes) pool_next[prev] = PtrW'(n);
                  else head_ptr[b] = PtrW'(n);
               end
            end
         end
         CMD_GET: if (a.found) a.value_out = pool_val[cur];
         CMD_REMOVE: begin
            if (a.found) begin
               a.value_out = pool_val[cur];
               if (prev < Nodes) pool_next[prev] = pool_next[cur];
               else head_ptr[b] = pool_next[cur];
               pool_used[cur] = 1'b0;
               pool_next[cur] = PtrW'(Nodes);
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type e;
      int errs;
      errs = 0;
      if (reset) begin
         clear_table();
         answers_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (answers_due.size() == 0) begin
               $error("response transfer with nothing outstanding");
               errs++;
            end else begin
               e = answers_due.pop_front();
               if (rsp.found !== e.found) begin
                  $error("found: expected %0d, actual %0d", e.found, rsp.found);
                  errs++;
               end
               if (rsp.value_out !== e.value_out) begin
                  $error("value_out: expected %0h, actual %0h", e.value_out, rsp.value_out);
                  errs++;
               end
               if (rsp.status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp.status);
                  errs++;
               end
            end
         end
         if (req.valid && req.ready)
            answers_due.push_back(apply_request(cmd_type'(req.cmd), req.key, req.value));
         if (csr_we) bkt_cfg = csr_wdata;
         fail_count <= fail_count + errs;
      end
      pending_count <= answers_due.size();
   end
endmodule

@@ test/chained_hash_table_tb.sv @@
// Testbench top: drives requests, configuration and response stalls; reports the verdict.
`timescale 1ns / 1ps
module chained_hash_table_tb;
   import cht_pkg::*;

   localparam int IdleLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CfgW-1:0] csr_wdata = '0;
   int fail_count, pending_count;
   int idle_cycles = 0;
   bit calm = 1'b0;
   logic [KeyW-1:0] keys_used [$];

   cht_req_if req ();
   cht_rsp_if rsp ();

   chained_hash_table uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   cht_checker checker_i (
      .clock(clock), .reset(reset), .req(req.monitor), .rsp(rsp.monitor),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response stalls in bursts
   always @(posedge clock) begin
      int gap;
      if (calm || $urandom_range(0, 3) != 0) rsp.ready <= 1'b1;
      else begin
         gap = $urandom_range(1, 15);
         rsp.ready <= 1'b0;
         repeat (gap) @(posedge clock);
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // valid stays high after a transfer until the next item or an idle burst replaces it
   task automatic send(cmd_type op, logic [KeyW-1:0] k, logic [ValW-1:0] v);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= op;
      req.key <= k;
      req.value <= v;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic write_buckets(logic [CfgW-1:0] n);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [KeyW-1:0] pick_key();
      logic [KeyW-1:0] k;
      if (keys_used.size() != 0 && $urandom_range(0, 2) != 0)
         return keys_used[$urandom_range(0, keys_used.size() - 1)];
      k = ($urandom_range(0, 1) != 0) ? $urandom() : KeyW'($urandom_range(0, 300));
      keys_used.push_back(k);
      if (keys_used.size() > 400) void'(keys_used.pop_front());
      return k;
   endfunction

   task automatic random_phase(int count, int set_weight);
      cmd_type op;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 99) < set_weight) ? CMD_SET : cmd_type'($urandom_range(1, 3));
         send(op, pick_key(), $urandom());
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.cmd = '0;
      req.key = '0;
      req.value = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, collisions in one bucket, overwrite, remove mid-chain
      send(CMD_GET, 32'h0, 32'h0);
      send(CMD_SET, 32'h0, 32'hFFFF_FFFF);
      send(CMD_SET, 32'hFFFF_FFFF, 32'h0);
      send(CMD_SET, 32'd64, 32'h1234_5678);
      send(CMD_SET, 32'd128, 32'hAAAA_5555);
      send(CMD_HAS, 32'd64, 32'h0);
      send(CMD_SET, 32'd64, 32'h5555_AAAA);
      send(CMD_GET, 32'd64, 32'h0);
      send(CMD_REMOVE, 32'd64, 32'h0);
      send(CMD_GET, 32'd128, 32'h0);
      send(CMD_REMOVE, 32'd0, 32'h0);
      send(CMD_REMOVE, 32'd0, 32'h0);
      send(CMD_HAS, 32'hFFFF_FFFF, 32'h0);
      send(CMD_GET, 32'hFFFF_FFFF, 32'h0);
      // zero saturates to one bucket
      write_buckets(7'd0);
      send(CMD_GET, 32'd128, 32'h0);
      send(CMD_SET, 32'd7, 32'h7);
      write_buckets(7'd127);
      send(CMD_GET, 32'hFFFF_FFFF, 32'h0);
      send(CMD_HAS, 32'd7, 32'h0);
      // fill the pool past capacity through a few buckets
      write_buckets(7'd3);
      for (int i = 0; i < 262; i++) send(CMD_SET, 32'(1000 + i), $urandom());
      send(CMD_HAS, 32'd1005, 32'h0);
      for (int i = 0; i < 40; i++) send(CMD_REMOVE, 32'(1000 + 5 * i), 32'h0);
      random_phase(150, 40);
      write_buckets(7'd1);
      random_phase(150, 35);
      write_buckets(7'd64);
      random_phase(250, 30);
      write_buckets(7'd17);
      random_phase(200, 30);
      write_buckets(7'd100);
      calm = 1'b1;
      random_phase(200, 30);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
